// File: hdl/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types and constants for the CSV field splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package csvfs_pkg;

  // Line character codes
  localparam logic [7:0] ChrQuote = 8'h22;
  localparam logic [7:0] ChrComma = 8'h2C;
  localparam logic [7:0] ChrLf    = 8'h0A;
  localparam logic [7:0] ChrCr    = 8'h0D;
  localparam logic [7:0] ChrNul   = 8'h00;

  // Column cap: hardware never tracks more than this many fields per line
  localparam int unsigned MaxCols = 32;
  localparam int unsigned ColCap  = (MaxCols < 32) ? MaxCols : 32;
  localparam logic [5:0]  LimCap  = 6'(ColCap);

  localparam int unsigned FieldW = 5;
  localparam int unsigned LimW   = 6;

  // Byte class decided by the front end
  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_QUOTE,
    CLS_COMMA,
    CLS_EOL
  } tok_cls_e;

  typedef struct packed {
    tok_cls_e   cls;
    logic [7:0] data;
  } token_t;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_FIELD,
    KIND_LINE
  } kind_e;

endpackage

`default_nettype wire

// File: hdl/csvfs_front.sv
// ----------------------------------------------------------------------------
// csvfs_front
// Classifies incoming line bytes and holds them in a two-entry token queue.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_front
  import csvfs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] byte_in_i,
  output logic            tok_valid_o,
  output token_t          tok_o,
  input  wire logic       tok_pop_i
);

  token_t      mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;
  token_t      tok_new;

  always_comb begin
    tok_new.data = byte_in_i;
    unique case (byte_in_i)
      ChrLf, ChrCr, ChrNul: tok_new.cls = CLS_EOL;
      ChrQuote:             tok_new.cls = CLS_QUOTE;
      ChrComma:             tok_new.cls = CLS_COMMA;
      default:              tok_new.cls = CLS_OTHER;
    endcase
  end

  assign in_stall_o  = cnt_q[1];
  assign tok_valid_o = (cnt_q != 2'd0);
  assign tok_o       = mem_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = tok_pop_i && tok_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= tok_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// File: hdl/csvfs_back.sv
// ----------------------------------------------------------------------------
// csvfs_back
// Quote/field state tracking and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_back
  import csvfs_pkg::*;
#(
  parameter int unsigned CELL_LEN = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [5:0] cfg_wdata_i,
  input  wire logic       tok_valid_i,
  input  wire token_t     tok_i,
  output logic            tok_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      cell_char_o,
  output logic [4:0]      field_number_o,
  output logic [5:0]      char_position_o,
  output logic [5:0]      field_count_o
);

  localparam int unsigned LenW = $clog2(CELL_LEN);
  localparam logic [LenW-1:0] LenMax = LenW'(CELL_LEN - 1);

  logic [LimW-1:0]   limit_q;
  logic              quoted_q, quoted_d;
  logic              pend_q, pend_d;
  logic              stop_q, stop_d;
  logic [FieldW-1:0] field_q, field_d;
  logic [LenW-1:0]   len_q, len_d;

  logic              out_valid_q;
  kind_e             kind_q, kind_d;
  logic [7:0]        char_q, char_d;
  logic [FieldW-1:0] fnum_q;
  logic [5:0]        pos_q, pos_d;
  logic [5:0]        cnt_q, cnt_d;

  logic              take, emit, keep, unq;
  logic [7:0]        keep_chr;
  logic [LimW-1:0]   lim, next_cnt;

  always_comb begin
    lim = limit_q;
    if (lim == '0)    lim = 6'd1;
    if (lim > LimCap) lim = LimCap;
  end

  assign next_cnt  = {1'b0, field_q} + 6'd1;
  assign take      = tok_valid_i && (!out_valid_q || !out_stall_i);
  assign tok_pop_o = take;

  always_comb begin
    quoted_d = quoted_q;
    pend_d   = pend_q;
    stop_d   = stop_q;
    field_d  = field_q;
    len_d    = len_q;
    emit     = 1'b0;
    kind_d   = KIND_CHAR;
    char_d   = '0;
    pos_d    = '0;
    cnt_d    = '0;
    keep     = 1'b0;
    keep_chr = tok_i.data;
    unq      = 1'b0;

    if (tok_i.cls == CLS_EOL) begin
      emit     = 1'b1;
      kind_d   = KIND_LINE;
      cnt_d    = next_cnt;
      quoted_d = 1'b0;
      pend_d   = 1'b0;
      stop_d   = 1'b0;
      field_d  = '0;
      len_d    = '0;
    end else if (!stop_q) begin
      if (quoted_q) begin
        if (pend_q) begin
          pend_d = 1'b0;
          if (tok_i.cls == CLS_QUOTE) begin
            keep     = 1'b1;
            keep_chr = ChrQuote;
          end else begin
            quoted_d = 1'b0;
            unq      = 1'b1;
          end
        end else if (tok_i.cls == CLS_QUOTE) begin
          pend_d = 1'b1;
        end else begin
          keep = 1'b1;
        end
      end else begin
        unq = 1'b1;
      end

      if (unq) begin
        case (tok_i.cls)
          CLS_QUOTE: quoted_d = 1'b1;
          CLS_COMMA: begin
            emit   = 1'b1;
            kind_d = KIND_FIELD;
            if (next_cnt >= lim) begin
              stop_d = 1'b1;
            end else begin
              field_d = field_q + 1'b1;
              len_d   = '0;
            end
          end
          default: keep = 1'b1;
        endcase
      end

      // cell full: drop silently
      if (keep && (len_q != LenMax)) begin
        emit   = 1'b1;
        kind_d = KIND_CHAR;
        char_d = keep_chr;
        pos_d  = 6'(len_q);
        len_d  = len_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= kind_d;
      char_q <= char_d;
      fnum_q <= field_q;
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= 6'd32;
      quoted_q    <= 1'b0;
      pend_q      <= 1'b0;
      stop_q      <= 1'b0;
      field_q     <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (take) begin
        quoted_q    <= quoted_d;
        pend_q      <= pend_d;
        stop_q      <= stop_d;
        field_q     <= field_d;
        len_q       <= len_d;
        out_valid_q <= emit;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign cell_char_o     = char_q;
  assign field_number_o  = fnum_q;
  assign char_position_o = pos_q;
  assign field_count_o   = cnt_q;

endmodule

`default_nettype wire

// File: hdl/csv_field_splitter.sv
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits a CSV line, one byte per request, into cell characters and ends.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with byte_in_i, one line byte per
//   request. LF, CR or NUL ends the line.
//   Output channel: out_valid_o / out_stall_i with kind_o, cell_char_o,
//   field_number_o, char_position_o and field_count_o. Zero or one result
//   request per input byte (opening and closing quotes, the first quote of
//   a pair, dropped bytes and non-end bytes after the field limit give none).
//   Config: cfg_we_i writes cfg_wdata_i into the field limit; write only
//   while the block is idle.
// Timing:
//   One byte per cycle sustained while out_stall_i is low. An accepted byte
//   passes the token queue, then the result register. The front end
//   classifies into a 2-entry token queue; the back end updates quote/field
//   state and loads the result register, one token per cycle while it is free.
// Reset: clears quote and field state and the queue; field limit goes to 32.
// Stall: a stalled result holds; the back end keeps taking tokens only while
//   the result register is free, then the queue fills and in_stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_splitter
  import csvfs_pkg::*;
#(
  parameter int unsigned CELL_LEN = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [5:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] byte_in_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      cell_char_o,
  output logic [4:0]      field_number_o,
  output logic [5:0]      char_position_o,
  output logic [5:0]      field_count_o
);

  // front -> back token path
  logic   tok_valid;
  token_t tok;
  logic   tok_pop;

  csvfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .byte_in_i   (byte_in_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_pop_i   (tok_pop)
  );

  csvfs_back #(
    .CELL_LEN (CELL_LEN)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .tok_valid_i     (tok_valid),
    .tok_i           (tok),
    .tok_pop_o       (tok_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .cell_char_o     (cell_char_o),
    .field_number_o  (field_number_o),
    .char_position_o (char_position_o),
    .field_count_o   (field_count_o)
  );

endmodule

`default_nettype wire
